### design/binomial_checkpoint_advance_core_assert.svh
// assertion macros used by bca_ctrl
`ifndef BINOMIAL_CHECKPOINT_ADVANCE_CORE_ASSERT_SVH
`define BINOMIAL_CHECKPOINT_ADVANCE_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define BCA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define BCA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### design/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// types shared by the checkpoint advance controller and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bca_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_start;
        logic div_start;
        logic finish;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic special;
        logic beta_done;
        logic div_busy;
    } stat_t;

endpackage
`default_nettype wire

### design/bca_ctrl.sv
// ----------------------------------------------------------------------------
// bca_ctrl
// sequencer for load, search passes, finish and output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binomial_checkpoint_advance_core_assert.svh"
module bca_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bca_pkg::cmd_t       cmd,
    input  wire bca_pkg::stat_t stat
);
    bca_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bca_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bca_pkg::ST_IDLE:
                if (in_valid) state_next = bca_pkg::ST_MUL;
            bca_pkg::ST_MUL:
                if (stat.special || stat.beta_done) state_next = bca_pkg::ST_FINISH;
                else state_next = bca_pkg::ST_DIV;
            bca_pkg::ST_DIV:
                if (!stat.div_busy) state_next = bca_pkg::ST_MUL;
            bca_pkg::ST_FINISH:
                state_next = bca_pkg::ST_OUT;
            bca_pkg::ST_OUT:
                if (out_ready) state_next = bca_pkg::ST_IDLE;
            default:
                state_next = bca_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == bca_pkg::ST_IDLE);
        out_valid     = (state_reg == bca_pkg::ST_OUT);
        cmd.load      = (state_reg == bca_pkg::ST_IDLE) && in_valid;
        cmd.mul_start = (state_reg == bca_pkg::ST_MUL) && !stat.special && !stat.beta_done;
        cmd.div_start = 1'b0;
        cmd.finish    = (state_reg == bca_pkg::ST_FINISH);
        case (state_reg)
            bca_pkg::ST_DIV: cmd.div_start = 1'b0;
            default:         cmd.div_start = cmd.mul_start;
        endcase
    end

    `BCA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `BCA_ASSERT_NEXT(a_load_mul, clk, rst_n, cmd.load, state_reg == bca_pkg::ST_MUL)
    `BCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

### design/bca_dp.sv
// ----------------------------------------------------------------------------
// bca_dp
// running binomial coefficient with serial divider and window arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bca_dp
#(
    parameter int STEP_WIDTH   = 32,
    parameter int BUDGET_WIDTH = 12
)
(
    input  wire logic                    clk,
    input  wire logic [STEP_WIDTH-1:0]   step_count,
    input  wire logic [BUDGET_WIDTH-1:0] slot_budget,
    input  wire bca_pkg::cmd_t           cmd,
    output bca_pkg::stat_t               stat,
    output logic [STEP_WIDTH-1:0]        advance
);
    localparam int PW = STEP_WIDTH + BUDGET_WIDTH;
    localparam int CW = $clog2(PW + 1);

    logic [STEP_WIDTH-1:0]   n_reg;
    logic [BUDGET_WIDTH-1:0] s_reg;
    // beta can reach about n*(s+1), so it is kept at full product width
    logic [PW-1:0]           beta_reg, prev_reg;
    logic [STEP_WIDTH-1:0]   t_reg;
    logic [PW-1:0]           quo_reg, rem_reg, num_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg;
    logic [STEP_WIDTH-1:0]   advance_reg;

    // divisor is t+1 for the coming pass
    logic [STEP_WIDTH:0] div_t;
    logic [PW:0]         rem_sh;
    logic                rem_ge;
    assign div_t  = {1'b0, t_reg} + 1'b1;
    assign rem_sh = {rem_reg, num_reg[PW-1]};
    assign rem_ge = rem_sh >= {{(PW-STEP_WIDTH){1'b0}}, div_t};

    // search and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= step_count;
            s_reg    <= slot_budget;
            beta_reg <= PW'(1);
            prev_reg <= PW'(1);
            t_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            num_reg  <= beta_reg * PW'(s_reg);
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= CW'(PW);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[PW-2:0], rem_ge};
            rem_reg <= rem_ge ? PW'(rem_sh - {{(PW-STEP_WIDTH){1'b0}}, div_t}) : rem_sh[PW-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                t_reg    <= div_t[STEP_WIDTH-1:0];
                prev_reg <= beta_reg;
                beta_reg <= beta_reg + {quo_reg[PW-2:0], rem_ge};
            end
        end
    end

    // window, midpoint and cap
    logic [PW-1:0] n_w, gap, lo, hi, mid, cap, s1;
    always_comb
    begin
        n_w = PW'(n_reg);
        s1  = PW'(s_reg) - 1'b1;
        gap = beta_reg - prev_reg;
        lo  = (gap >= n_w) ? PW'(1) : n_w - gap;
        hi  = (prev_reg > n_w - 1'b1) ? n_w - 1'b1 : prev_reg;
        mid = (lo + hi) >> 1;
        cap = n_w - s1;
        if (s1 >= n_w) mid = PW'(1);
        else if (mid > cap) mid = cap;
        if (mid == '0) mid = PW'(1);
        if (n_reg == '0) mid = '0;
        else if (n_reg == STEP_WIDTH'(1)) mid = PW'(1);
        else if (s_reg <= BUDGET_WIDTH'(1)) mid = n_w;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            advance_reg <= mid[STEP_WIDTH-1:0];
    end

    assign advance        = advance_reg;
    assign stat.special   = (n_reg <= STEP_WIDTH'(1)) || (s_reg <= BUDGET_WIDTH'(1));
    assign stat.beta_done = beta_reg >= n_w;
    assign stat.div_busy  = busy_reg;
endmodule
`default_nettype wire

### design/binomial_checkpoint_advance_core.sv
// ----------------------------------------------------------------------------
// binomial_checkpoint_advance_core
// step advance for binomial checkpointing of an interval
// ----------------------------------------------------------------------------
// One word at a time. The search for the smallest t with C(s+t,t) >= n does
// one pass per t, and each pass runs a restoring divider one quotient bit per
// cycle; special inputs (n <= 1 or s <= 1) skip the search passes.
`timescale 1ns / 1ps
`default_nettype none
module binomial_checkpoint_advance_core
#(
    parameter int STEP_WIDTH   = 32,
    parameter int BUDGET_WIDTH = 12
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [STEP_WIDTH-1:0]   step_count,
    input  wire logic [BUDGET_WIDTH-1:0] slot_budget,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STEP_WIDTH-1:0]        advance
);
    bca_pkg::cmd_t  cmd;
    bca_pkg::stat_t stat;

    // controller
    bca_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath
    bca_dp #(.STEP_WIDTH(STEP_WIDTH), .BUDGET_WIDTH(BUDGET_WIDTH)) u_dp
    (
        .clk         (clk),
        .step_count  (step_count),
        .slot_budget (slot_budget),
        .cmd         (cmd),
        .stat        (stat),
        .advance     (advance)
    );
endmodule
`default_nettype wire
